// ===== sv/lgt_pkg.sv =====
// Shared constants and types for the toroidal life grid block.
package lgt_pkg;

    // Grid size
    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 32;

    // Derived widths
    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int COL_AW = $clog2(GRID_COLS);
    localparam int CNT_W  = $clog2(GRID_ROWS + 3);

    // B3/S23 rule
    localparam logic [3:0] LIFE_BIRTH = 4'd3;
    localparam logic [3:0] LIFE_KEEP  = 4'd2;

    // Action codes of an input beat
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2
    } action_t;

endpackage

// ===== sv/lgt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/lgt_row_unit.sv =====
// Next-generation unit for one grid row from its wrapped three-row window.
module lgt_row_unit (
    input  logic [lgt_pkg::GRID_COLS-1:0] up_row,
    input  logic [lgt_pkg::GRID_COLS-1:0] mid_row,
    input  logic [lgt_pkg::GRID_COLS-1:0] down_row,
    output logic [lgt_pkg::GRID_COLS-1:0] new_row
);
    import lgt_pkg::*;

    // Per-column neighbor count and rule, columns wrap at the edges
    always_comb
    begin
        int         cl;
        int         cr;
        logic [3:0] live;
        new_row = '0;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            cl = (c == 0) ? GRID_COLS - 1 : c - 1;
            cr = (c == GRID_COLS - 1) ? 0 : c + 1;
            live = 4'(up_row[cl]) + 4'(up_row[c]) + 4'(up_row[cr])
                 + 4'(mid_row[cl]) + 4'(mid_row[cr])
                 + 4'(down_row[cl]) + 4'(down_row[c]) + 4'(down_row[cr]);
            if (mid_row[c])
            begin
                new_row[c] = (live == LIFE_KEEP) || (live == LIFE_BIRTH);
            end
            else
            begin
                new_row[c] = (live == LIFE_BIRTH);
            end
        end
    end

endmodule

// ===== sv/life_automaton_torus_step_core.sv =====
// Toroidal B3/S23 life grid: row RAM, row window and step sequencer.
//
// Input channel (in_valid / in_stall) carries one beat per command: action,
// row, col and cell_in. Action 0 writes one cell, 1 reads one cell, 2 advances
// the whole grid one generation; any other code does nothing. Every accepted
// beat yields exactly one output beat (cell_out, step_done) on the output
// channel (out_valid / out_stall).
// A cell write or read passes through the cell and finish states, an unused code
// goes straight to the finish state, and a generation step runs the step sweep
// before the finish state; in_stall drops in the same cycle as out_valid rises.
// The grid lives in a row RAM with one read and one write port; a step reads one
// row per cycle through a three-row window and writes each new row in place once
// its old value is no longer needed; the wrap rows are held in registers.
// in_stall is high from acceptance until the result has been loaded into the
// output register, so one command is worked on at a time. A new beat is taken
// while an earlier result still waits in the output register; the next result
// then waits until that one has been taken. A stalled output holds its beat.
// Reset clears per-row valid flags, so the whole grid reads as dead at once;
// no clearing pass is needed.
module life_automaton_torus_step_core (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [4:0] row,
    input  logic [4:0] col,
    input  logic       cell_in,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       cell_out,
    output logic       step_done
);
    import lgt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(GRID_ROWS + 2);

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    action_t                action_reg;
    logic [4:0]             row_reg;
    logic [4:0]             col_reg;
    logic                   cell_in_reg;
    logic                   res_cell_reg;
    logic                   res_step_reg;
    logic                   out_vld_reg;
    logic                   cell_out_reg;
    logic                   step_done_reg;
    logic [GRID_ROWS-1:0]   row_vld_reg;
    logic                   rvld_reg;
    logic [GRID_COLS-1:0]   prev_reg;
    logic [GRID_COLS-1:0]   cur_reg;
    logic [GRID_COLS-1:0]   first_reg;

    logic                   in_fire;
    logic                   in_grid;
    logic                   slot_free;
    logic                   ram_we;
    logic [ROW_AW-1:0]      ram_waddr;
    logic [GRID_COLS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [ROW_AW-1:0]      ram_raddr;
    logic [GRID_COLS-1:0]   ram_rdata;
    logic [GRID_COLS-1:0]   row_data;
    logic [GRID_COLS-1:0]   down_row;
    logic [GRID_COLS-1:0]   new_row;
    logic [GRID_COLS-1:0]   col_mask;
    logic [COL_AW-1:0]      col_idx;

    // Handshake and indexing helpers
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign in_grid   = (32'(row) < 32'(GRID_ROWS)) && (32'(col) < 32'(GRID_COLS));
    assign slot_free = !out_vld_reg || !out_stall;
    assign out_valid = out_vld_reg;
    assign cell_out  = cell_out_reg;
    assign step_done = step_done_reg;

    // Rows never written since reset read as dead
    assign row_data = ram_rdata & {GRID_COLS{rvld_reg}};
    assign col_idx  = COL_AW'(col_reg);
    assign col_mask = GRID_COLS'(1) << col_idx;
    assign down_row = (cnt_reg == STEP_LAST) ? first_reg : row_data;

    lgt_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lgt_row_unit u_row_unit (
        .up_row   (prev_reg),
        .mid_row  (cur_reg),
        .down_row (down_row),
        .new_row  (new_row)
    );

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = new_row;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // fetch the addressed row for a cell write or read
                ram_raddr = ROW_AW'(row);
                ram_re    = in_fire && in_grid &&
                            ((action == ACT_WRITE) || (action == ACT_READ));
            end
            ST_CELL:
            begin
                // read-modify-write of one cell for a write; a read only samples the fetched row
                ram_waddr = ROW_AW'(row_reg);
                ram_wdata = (row_data & ~col_mask) | (cell_in_reg ? col_mask : '0);
                ram_we    = (action_reg == ACT_WRITE);
            end
            ST_STEP:
            begin
                // issue: last row first, then rows 0 .. GRID_ROWS-1
                ram_re    = (32'(cnt_reg) <= GRID_ROWS);
                ram_raddr = (cnt_reg == '0) ? ROW_AW'(GRID_ROWS - 1)
                                            : ROW_AW'(cnt_reg - CNT_W'(1));
                // new row cnt-3 is ready once its lower neighbor has arrived
                ram_we    = (cnt_reg >= CNT_W'(3));
                ram_waddr = ROW_AW'(cnt_reg - CNT_W'(3));
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, window and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_vld_reg   <= 1'b0;
            row_vld_reg   <= '0;
            rvld_reg      <= 1'b0;
            action_reg    <= ACT_WRITE;
            res_cell_reg  <= 1'b0;
            res_step_reg  <= 1'b0;
            cell_out_reg  <= 1'b0;
            step_done_reg <= 1'b0;
        end
        else
        begin
            // taken beat leaves, unless the finish state reloads the register
            if (out_vld_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_vld_reg <= 1'b0;
            end
            if (ram_re)
            begin
                rvld_reg <= row_vld_reg[ram_raddr];
            end
            if (ram_we)
            begin
                row_vld_reg[ram_waddr] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        action_reg   <= action_t'(action);
                        row_reg      <= row;
                        col_reg      <= col;
                        cell_in_reg  <= cell_in;
                        res_cell_reg <= 1'b0;
                        res_step_reg <= 1'b0;
                        cnt_reg      <= '0;
                        if (action == ACT_STEP)
                        begin
                            state_reg <= ST_STEP;
                        end
                        else if (in_grid &&
                                 ((action == ACT_WRITE) || (action == ACT_READ)))
                        begin
                            state_reg <= ST_CELL;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_CELL:
                begin
                    if (action_reg == ACT_READ)
                    begin
                        res_cell_reg <= row_data[col_idx];
                    end
                    state_reg <= ST_FINISH;
                end
                ST_STEP:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        prev_reg <= row_data;
                    end
                    else if (cnt_reg == CNT_W'(2))
                    begin
                        cur_reg   <= row_data;
                        first_reg <= row_data;
                    end
                    else if (cnt_reg == STEP_LAST)
                    begin
                        res_step_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end
                    else if (cnt_reg > CNT_W'(2))
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= row_data;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_vld_reg   <= 1'b1;
                        cell_out_reg  <= res_cell_reg;
                        step_done_reg <= res_step_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A new output beat only comes out of the finish state
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !$past(out_vld_reg)) |-> ($past(state_reg) == ST_FINISH))
        else $error("output beat without finish state");

    // A beat never reports both a read bit and a finished step
    a_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(cell_out && step_done))
        else $error("cell_out and step_done both set");

    // Step counter stays inside the sweep
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (cnt_reg <= STEP_LAST))
        else $error("step counter out of range");

    // The grid RAM is only written while a command is in progress
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CELL) || (state_reg == ST_STEP)))
        else $error("grid write outside a command");

endmodule
